FILE: sv/qmj_pkg.sv
// Shared constants and types of the quintic minimum-jerk coefficient block.
package qmj_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int MUL_CHUNK = 32;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_ZERO = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

FILE: sv/qmj_front.sv
// Front end: accepts request transactions and prepares the linear terms of each one.
module qmj_front #(
   parameter int WORD_BITS = qmj_pkg::WORD_BITS_DEF
) (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [WORD_BITS-1:0]   req_start_position,
   input  logic [WORD_BITS-1:0]   req_start_velocity,
   input  logic [WORD_BITS-1:0]   req_start_accel,
   input  logic [WORD_BITS-1:0]   req_end_position,
   input  logic [WORD_BITS-1:0]   req_end_velocity,
   input  logic [WORD_BITS-1:0]   req_end_accel,
   input  logic [WORD_BITS-2:0]   req_duration,
   input  qmj_pkg::qstat_type     qstat,
   output logic                   push,
   output logic                   zero,
   output logic [WORD_BITS-1:0]   coef_0,
   output logic [WORD_BITS-1:0]   coef_1,
   output logic [WORD_BITS-1:0]   coef_2,
   output logic [WORD_BITS:0]     h,
   output logic [WORD_BITS+4:0]   b3,
   output logic [WORD_BITS+4:0]   b4,
   output logic [WORD_BITS+4:0]   b5,
   output logic [WORD_BITS+4:0]   c3,
   output logic [WORD_BITS+4:0]   c4,
   output logic [WORD_BITS+4:0]   c5,
   output logic [WORD_BITS-2:0]   t
);

   localparam int W = WORD_BITS;
   localparam int VW = W + 5;

   logic [VW-1:0] ve;
   logic [VW-1:0] v0;
   logic [VW-1:0] ae;
   logic [VW-1:0] a0;
   logic [VW-1:0] vs;

   assign req_stall = qstat.full;
   assign push = req_valid & ~qstat.full;

   assign zero = (req_duration == '0);
   assign t = req_duration;
   assign coef_0 = req_start_position;
   assign coef_1 = req_start_velocity;
   assign coef_2 = {req_start_accel[W-1], req_start_accel[W-1:1]}
                   + W'(req_start_accel[0] & ~req_start_accel[W-1]);
   assign h = {req_end_position[W-1], req_end_position}
              - {req_start_position[W-1], req_start_position};

   assign ve = {{5{req_end_velocity[W-1]}}, req_end_velocity};
   assign v0 = {{5{req_start_velocity[W-1]}}, req_start_velocity};
   assign ae = {{5{req_end_accel[W-1]}}, req_end_accel};
   assign a0 = {{5{req_start_accel[W-1]}}, req_start_accel};
   assign vs = ve + v0;

   assign b3 = (ve << 3) + (v0 << 3) + (v0 << 2);
   assign b4 = (ve << 4) - (ve << 1) + (v0 << 4);
   assign b5 = (vs << 2) + (vs << 1);
   assign c3 = (a0 << 1) + a0 - ae;
   assign c4 = (a0 << 1) + a0 - (ae << 1);
   assign c5 = a0 - ae;

endmodule

FILE: sv/qmj_fifo.sv
// Short queue that decouples the front end from the arithmetic back end.
module qmj_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = qmj_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   din,
   input  logic               pop,
   output logic [WIDTH-1:0]   dout,
   output qmj_pkg::qstat_type qstat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW-1:0]    rd_ptr_in;
   logic [CW-1:0]    cnt_ff;
   logic [CW-1:0]    cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10: cnt_in = cnt_ff + 1'b1;
         2'b01: cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout = mem_ff[rd_ptr_ff];
   assign qstat.full = (cnt_ff == CW'(DEPTH));
   assign qstat.empty = (cnt_ff == '0);

endmodule

FILE: sv/qmj_delay.sv
// Enabled shift register that aligns operands across the back-end pipeline.
module qmj_delay #(
   parameter int WID = 1,
   parameter int LEN = 1
) (
   input  logic           clock,
   input  logic           en,
   input  logic [WID-1:0] din,
   output logic [WID-1:0] dout
);

   logic [WID-1:0] sh_ff [LEN];

   always_ff @(posedge clock) begin
      if (en) begin
         sh_ff[0] <= din;
         for (int k = 1; k < LEN; k++) begin
            sh_ff[k] <= sh_ff[k-1];
         end
      end
   end

   assign dout = sh_ff[LEN-1];

endmodule

FILE: sv/qmj_mul.sv
// Two-stage unsigned multiplier built from registered chunk partial products.
module qmj_mul #(
   parameter int A_BITS = 32,
   parameter int B_BITS = 32
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [A_BITS-1:0]        a,
   input  logic [B_BITS-1:0]        b,
   output logic [A_BITS+B_BITS-1:0] p
);

   localparam int CH = qmj_pkg::MUL_CHUNK;
   localparam int NA = (A_BITS + CH - 1) / CH;
   localparam int NB = (B_BITS + CH - 1) / CH;
   localparam int PW = A_BITS + B_BITS;
   localparam int SW = (NA + NB) * CH;

   logic [NA*CH-1:0] a_pad;
   logic [NB*CH-1:0] b_pad;
   logic [2*CH-1:0]  pp_in [NA*NB];
   logic [2*CH-1:0]  pp_ff [NA*NB];
   logic [SW-1:0]    sum;
   logic [PW-1:0]    p_ff;

   assign a_pad = (NA*CH)'(a);
   assign b_pad = (NB*CH)'(b);

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i*NB+j] = (2*CH)'(a_pad[i*CH +: CH]) * (2*CH)'(b_pad[j*CH +: CH]);
         end
      end
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum = sum + (SW'(pp_ff[i*NB+j]) << (CH * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff <= pp_in;
         p_ff <= sum[PW-1:0];
      end
   end

   assign p = p_ff;

endmodule

FILE: sv/qmj_div.sv
// Pipelined restoring divider with round to nearest, ties away from zero, and saturation.
module qmj_div #(
   parameter int X_BITS = 64,
   parameter int D_BITS = 32,
   parameter int WORD_BITS = qmj_pkg::WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [X_BITS-1:0]    x,
   input  logic [D_BITS-1:0]    d,
   output logic [WORD_BITS-1:0] q,
   output logic                 sat
);

   localparam int W = WORD_BITS;
   localparam int QB = W + 1;
   localparam int NPW = ((X_BITS + 1 > D_BITS) ? X_BITS + 1 : D_BITS) + 1;
   localparam int RW = D_BITS + 1 + QB;
   localparam int CW = ((NPW > RW) ? NPW : RW) + 1;

   logic [X_BITS-1:0] mag;
   logic [NPW-1:0]    np;
   logic [D_BITS:0]   dp;
   logic              ovf;

   logic [RW-1:0]     rem_in [QB+1];
   logic [RW-1:0]     rem_ff [QB+1];
   logic [QB-1:0]     qb_in  [QB+1];
   logic [QB-1:0]     qb_ff  [QB+1];
   logic [D_BITS:0]   dp_in  [QB+1];
   logic [D_BITS:0]   dp_ff  [QB+1];
   logic              neg_in [QB+1];
   logic              neg_ff [QB+1];
   logic              ovf_in [QB+1];
   logic              ovf_ff [QB+1];
   logic [RW-1:0]     trial  [QB];

   logic [QB-1:0]     qmag;
   logic [QB-1:0]     qneg;
   logic              sat_in;
   logic [W-1:0]      q_in;
   logic [W-1:0]      q_ff;
   logic              sat_ff;

   always_comb begin
      mag = x[X_BITS-1] ? (~x + 1'b1) : x;
      np = NPW'({mag, 1'b0}) + NPW'(d);
      dp = {d, 1'b0};
      ovf = (CW'(np) >= (CW'(dp) << QB));
      rem_in[0] = RW'(np);
      qb_in[0] = '0;
      dp_in[0] = dp;
      neg_in[0] = x[X_BITS-1];
      ovf_in[0] = ovf;
      for (int k = 0; k < QB; k++) begin
         trial[k] = RW'(dp_ff[k]) << (QB - 1 - k);
         dp_in[k+1] = dp_ff[k];
         neg_in[k+1] = neg_ff[k];
         ovf_in[k+1] = ovf_ff[k];
         if (rem_ff[k] >= trial[k]) begin
            rem_in[k+1] = rem_ff[k] - trial[k];
            qb_in[k+1] = qb_ff[k] | (QB'(1) << (QB - 1 - k));
         end else begin
            rem_in[k+1] = rem_ff[k];
            qb_in[k+1] = qb_ff[k];
         end
      end
   end

   always_comb begin
      qmag = qb_ff[QB];
      qneg = ~qmag + 1'b1;
      sat_in = ovf_ff[QB]
               | (~neg_ff[QB] & (qmag > QB'({(W-1){1'b1}})))
               | (neg_ff[QB] & (qmag > (QB'(1) << (W - 1))));
      if (sat_in) begin
         q_in = neg_ff[QB] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         q_in = neg_ff[QB] ? qneg[W-1:0] : qmag[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= QB; k++) begin
            rem_ff[k] <= rem_in[k];
            qb_ff[k] <= qb_in[k];
            dp_ff[k] <= dp_in[k];
            neg_ff[k] <= neg_in[k];
            ovf_ff[k] <= ovf_in[k];
         end
         q_ff <= q_in;
         sat_ff <= sat_in;
      end
   end

   assign q = q_ff;
   assign sat = sat_ff;

endmodule

FILE: sv/qmj_back.sv
// Back end: powers of the duration, numerators, three dividers and the result register.
module qmj_back #(
   parameter int WORD_BITS = qmj_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = qmj_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  qmj_pkg::qstat_type     qstat,
   input  logic [11*WORD_BITS+30:0] q_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WORD_BITS-1:0]   rsp_coef_0,
   output logic [WORD_BITS-1:0]   rsp_coef_1,
   output logic [WORD_BITS-1:0]   rsp_coef_2,
   output logic [WORD_BITS-1:0]   rsp_coef_3,
   output logic [WORD_BITS-1:0]   rsp_coef_4,
   output logic [WORD_BITS-1:0]   rsp_coef_5,
   output logic [1:0]             rsp_status
);

   localparam int W = WORD_BITS;
   localparam int F = FRAC_BITS;
   localparam int TW = W - 1;
   localparam int VW = W + 5;
   localparam int NW = 3 * W + 2 * F + 8;
   localparam int XW = NW + 3 * F;
   localparam int DW = 5 * W - 4;
   localparam int QB = W + 1;
   localparam int LAT = QB + 8;
   localparam int SW = 3 * W + 1;

   logic          en;
   logic          zero;
   logic [W-1:0]  c0;
   logic [W-1:0]  c1;
   logic [W-1:0]  c2;
   logic [W:0]    h;
   logic [VW-1:0] b3;
   logic [VW-1:0] b4;
   logic [VW-1:0] b5;
   logic [VW-1:0] a3;
   logic [VW-1:0] a4;
   logic [VW-1:0] a5;
   logic [TW-1:0] t;

   logic [VW-1:0] bm3;
   logic [VW-1:0] bm4;
   logic [VW-1:0] bm5;
   logic [2*TW-1:0] t2;
   logic [VW+TW-1:0] bt3;
   logic [VW+TW-1:0] bt4;
   logic [VW+TW-1:0] bt5;
   logic [TW-1:0] t_d2;
   logic [TW-1:0] t_d4;
   logic [3*VW-1:0] a_d2;
   logic [W+3:0]  hs_d4;

   logic [VW-1:0] ad3;
   logic [VW-1:0] ad4;
   logic [VW-1:0] ad5;
   logic [VW-1:0] am3;
   logic [VW-1:0] am4;
   logic [VW-1:0] am5;
   logic [3*TW-1:0] t3;
   logic [4*TW-1:0] t4;
   logic [5*TW-1:0] t5;
   logic [VW+2*TW-1:0] ct3;
   logic [VW+2*TW-1:0] ct4;
   logic [VW+2*TW-1:0] ct5;
   logic [3*(VW+TW)-1:0] bt_d4;
   logic [2:0]    sa_d4;

   logic [W:0]    h4;
   logic          sb3;
   logic          sb4;
   logic          sb5;
   logic signed [NW-1:0] hs;
   logic signed [NW-1:0] hp3;
   logic signed [NW-1:0] hp4;
   logic signed [NW-1:0] hp5;
   logic signed [NW-1:0] pb3;
   logic signed [NW-1:0] pb4;
   logic signed [NW-1:0] pb5;
   logic signed [NW-1:0] pc3;
   logic signed [NW-1:0] pc4;
   logic signed [NW-1:0] pc5;
   logic signed [NW-1:0] n3;
   logic signed [NW-1:0] n4;
   logic signed [NW-1:0] n5;
   logic [3*XW-1:0] x_s4;
   logic [3*XW-1:0] x_s6;
   logic [2*DW-1:0] d_s4;
   logic [2*DW-1:0] d_s6;
   logic [DW-1:0] d5;

   logic [W-1:0]  q3;
   logic [W-1:0]  q4;
   logic [W-1:0]  q5;
   logic          sat3;
   logic          sat4;
   logic          sat5;
   logic [SW-1:0] side_d;
   logic          vld_ff [LAT];

   logic          rsp_valid_ff;
   logic [W-1:0]  coef_ff [6];
   qmj_pkg::status_type status_ff;

   assign {zero, c0, c1, c2, h, b3, b4, b5, a3, a4, a5, t} = q_data;
   assign en = ~rsp_valid_ff | ~rsp_stall;
   assign pop = en & ~qstat.empty;

   assign bm3 = b3[VW-1] ? (~b3 + 1'b1) : b3;
   assign bm4 = b4[VW-1] ? (~b4 + 1'b1) : b4;
   assign bm5 = b5[VW-1] ? (~b5 + 1'b1) : b5;

   qmj_mul #(.A_BITS(TW), .B_BITS(TW)) u_mul_t2 (
      .clock(clock), .en(en), .a(t), .b(t), .p(t2));
   qmj_mul #(.A_BITS(VW), .B_BITS(TW)) u_mul_bt3 (
      .clock(clock), .en(en), .a(bm3), .b(t), .p(bt3));
   qmj_mul #(.A_BITS(VW), .B_BITS(TW)) u_mul_bt4 (
      .clock(clock), .en(en), .a(bm4), .b(t), .p(bt4));
   qmj_mul #(.A_BITS(VW), .B_BITS(TW)) u_mul_bt5 (
      .clock(clock), .en(en), .a(bm5), .b(t), .p(bt5));

   qmj_delay #(.WID(TW), .LEN(2)) u_dly_t2 (
      .clock(clock), .en(en), .din(t), .dout(t_d2));
   qmj_delay #(.WID(TW), .LEN(2)) u_dly_t4 (
      .clock(clock), .en(en), .din(t_d2), .dout(t_d4));
   qmj_delay #(.WID(3*VW), .LEN(2)) u_dly_a (
      .clock(clock), .en(en), .din({a3, a4, a5}), .dout(a_d2));
   qmj_delay #(.WID(W+4), .LEN(4)) u_dly_h (
      .clock(clock), .en(en), .din({h, b3[VW-1], b4[VW-1], b5[VW-1]}), .dout(hs_d4));

   assign {ad3, ad4, ad5} = a_d2;
   assign am3 = ad3[VW-1] ? (~ad3 + 1'b1) : ad3;
   assign am4 = ad4[VW-1] ? (~ad4 + 1'b1) : ad4;
   assign am5 = ad5[VW-1] ? (~ad5 + 1'b1) : ad5;

   qmj_mul #(.A_BITS(2*TW), .B_BITS(TW)) u_mul_t3 (
      .clock(clock), .en(en), .a(t2), .b(t_d2), .p(t3));
   qmj_mul #(.A_BITS(2*TW), .B_BITS(2*TW)) u_mul_t4 (
      .clock(clock), .en(en), .a(t2), .b(t2), .p(t4));
   qmj_mul #(.A_BITS(VW), .B_BITS(2*TW)) u_mul_ct3 (
      .clock(clock), .en(en), .a(am3), .b(t2), .p(ct3));
   qmj_mul #(.A_BITS(VW), .B_BITS(2*TW)) u_mul_ct4 (
      .clock(clock), .en(en), .a(am4), .b(t2), .p(ct4));
   qmj_mul #(.A_BITS(VW), .B_BITS(2*TW)) u_mul_ct5 (
      .clock(clock), .en(en), .a(am5), .b(t2), .p(ct5));

   qmj_delay #(.WID(3*(VW+TW)), .LEN(2)) u_dly_bt (
      .clock(clock), .en(en), .din({bt3, bt4, bt5}), .dout(bt_d4));
   qmj_delay #(.WID(3), .LEN(2)) u_dly_sa (
      .clock(clock), .en(en), .din({ad3[VW-1], ad4[VW-1], ad5[VW-1]}), .dout(sa_d4));

   qmj_mul #(.A_BITS(4*TW), .B_BITS(TW)) u_mul_t5 (
      .clock(clock), .en(en), .a(t4), .b(t_d4), .p(t5));

   always_comb begin
      logic [NW-1:0] ub3;
      logic [NW-1:0] ub4;
      logic [NW-1:0] ub5;
      logic [NW-1:0] uc3;
      logic [NW-1:0] uc4;
      logic [NW-1:0] uc5;
      {h4, sb3, sb4, sb5} = hs_d4;
      hs = $signed({{(NW-W-1){h4[W]}}, h4}) <<< (2 * F);
      hp3 = (hs <<< 4) + (hs <<< 2);
      hp4 = (hs <<< 1) - (hs <<< 5);
      hp5 = (hs <<< 3) + (hs <<< 2);
      ub3 = NW'(bt_d4[2*(VW+TW) +: (VW+TW)]) << F;
      ub4 = NW'(bt_d4[(VW+TW) +: (VW+TW)]) << F;
      ub5 = NW'(bt_d4[0 +: (VW+TW)]) << F;
      uc3 = NW'(ct3);
      uc4 = NW'(ct4);
      uc5 = NW'(ct5);
      pb3 = sb3 ? -$signed(ub3) : $signed(ub3);
      pb4 = sb4 ? -$signed(ub4) : $signed(ub4);
      pb5 = sb5 ? -$signed(ub5) : $signed(ub5);
      pc3 = sa_d4[2] ? -$signed(uc3) : $signed(uc3);
      pc4 = sa_d4[1] ? -$signed(uc4) : $signed(uc4);
      pc5 = sa_d4[0] ? -$signed(uc5) : $signed(uc5);
      n3 = hp3 - pb3 - pc3;
      n4 = hp4 + pb4 + pc4;
      n5 = hp5 - pb5 - pc5;
      x_s4 = {({{(XW-NW){n3[NW-1]}}, n3} << F),
              ({{(XW-NW){n4[NW-1]}}, n4} << (2 * F)),
              ({{(XW-NW){n5[NW-1]}}, n5} << (3 * F))};
      d_s4 = {DW'({t3, 1'b0}), DW'({t4, 1'b0})};
   end

   qmj_delay #(.WID(3*XW), .LEN(2)) u_dly_x (
      .clock(clock), .en(en), .din(x_s4), .dout(x_s6));
   qmj_delay #(.WID(2*DW), .LEN(2)) u_dly_d (
      .clock(clock), .en(en), .din(d_s4), .dout(d_s6));

   assign d5 = DW'({t5, 1'b0});

   qmj_div #(.X_BITS(XW), .D_BITS(DW), .WORD_BITS(W)) u_div_c3 (
      .clock(clock), .en(en), .x(x_s6[2*XW +: XW]), .d(d_s6[DW +: DW]),
      .q(q3), .sat(sat3));
   qmj_div #(.X_BITS(XW), .D_BITS(DW), .WORD_BITS(W)) u_div_c4 (
      .clock(clock), .en(en), .x(x_s6[XW +: XW]), .d(d_s6[0 +: DW]),
      .q(q4), .sat(sat4));
   qmj_div #(.X_BITS(XW), .D_BITS(DW), .WORD_BITS(W)) u_div_c5 (
      .clock(clock), .en(en), .x(x_s6[0 +: XW]), .d(d5),
      .q(q5), .sat(sat5));

   qmj_delay #(.WID(SW), .LEN(LAT)) u_dly_side (
      .clock(clock), .en(en), .din({zero, c0, c1, c2}), .dout(side_d));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= ~qstat.empty;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (side_d[SW-1]) begin
            for (int k = 0; k < 6; k++) begin
               coef_ff[k] <= '0;
            end
            status_ff <= qmj_pkg::STATUS_ZERO;
         end else begin
            coef_ff[0] <= side_d[2*W +: W];
            coef_ff[1] <= side_d[W +: W];
            coef_ff[2] <= side_d[0 +: W];
            coef_ff[3] <= q3;
            coef_ff[4] <= q4;
            coef_ff[5] <= q5;
            status_ff <= (sat3 | sat4 | sat5) ? qmj_pkg::STATUS_SAT : qmj_pkg::STATUS_OK;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_coef_0 = coef_ff[0];
   assign rsp_coef_1 = coef_ff[1];
   assign rsp_coef_2 = coef_ff[2];
   assign rsp_coef_3 = coef_ff[3];
   assign rsp_coef_4 = coef_ff[4];
   assign rsp_coef_5 = coef_ff[5];
   assign rsp_status = status_ff;

endmodule

FILE: sv/quintic_min_jerk_coefficients.sv
// Top level: quintic minimum-jerk trajectory coefficients from start and end states.
// Throughput is one transaction per cycle while the response is not stalled, set by the fully
// pipelined chunk multipliers and the one-bit-per-stage restoring dividers of the back end.
// A stalled response holds the whole back end; a four-entry queue absorbs requests meanwhile.
// Synchronous reset empties the queue and clears all valid flags; no result is pending.
module quintic_min_jerk_coefficients #(
   parameter int WORD_BITS = qmj_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = qmj_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_BITS-1:0] req_start_position,
   input  logic [WORD_BITS-1:0] req_start_velocity,
   input  logic [WORD_BITS-1:0] req_start_accel,
   input  logic [WORD_BITS-1:0] req_end_position,
   input  logic [WORD_BITS-1:0] req_end_velocity,
   input  logic [WORD_BITS-1:0] req_end_accel,
   input  logic [WORD_BITS-2:0] req_duration,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_coef_0,
   output logic [WORD_BITS-1:0] rsp_coef_1,
   output logic [WORD_BITS-1:0] rsp_coef_2,
   output logic [WORD_BITS-1:0] rsp_coef_3,
   output logic [WORD_BITS-1:0] rsp_coef_4,
   output logic [WORD_BITS-1:0] rsp_coef_5,
   output logic [1:0]           rsp_status
);

   localparam int W = WORD_BITS;
   localparam int VW = W + 5;
   localparam int QW = 11 * W + 31;

   qmj_pkg::qstat_type qstat;
   logic          push;
   logic          pop;
   logic          zero;
   logic [W-1:0]  c0;
   logic [W-1:0]  c1;
   logic [W-1:0]  c2;
   logic [W:0]    h;
   logic [VW-1:0] b3;
   logic [VW-1:0] b4;
   logic [VW-1:0] b5;
   logic [VW-1:0] a3;
   logic [VW-1:0] a4;
   logic [VW-1:0] a5;
   logic [W-2:0]  t;
   logic [QW-1:0] q_din;
   logic [QW-1:0] q_dout;

   qmj_front #(.WORD_BITS(W)) u_front (
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_start_position(req_start_position),
      .req_start_velocity(req_start_velocity),
      .req_start_accel(req_start_accel),
      .req_end_position(req_end_position),
      .req_end_velocity(req_end_velocity),
      .req_end_accel(req_end_accel),
      .req_duration(req_duration),
      .qstat(qstat),
      .push(push),
      .zero(zero),
      .coef_0(c0),
      .coef_1(c1),
      .coef_2(c2),
      .h(h),
      .b3(b3),
      .b4(b4),
      .b5(b5),
      .c3(a3),
      .c4(a4),
      .c5(a5),
      .t(t)
   );

   assign q_din = {zero, c0, c1, c2, h, b3, b4, b5, a3, a4, a5, t};

   qmj_fifo #(.WIDTH(QW), .DEPTH(qmj_pkg::QUEUE_DEPTH)) u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .din(q_din),
      .pop(pop),
      .dout(q_dout),
      .qstat(qstat)
   );

   qmj_back #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock),
      .reset(reset),
      .qstat(qstat),
      .q_data(q_dout),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_coef_0(rsp_coef_0),
      .rsp_coef_1(rsp_coef_1),
      .rsp_coef_2(rsp_coef_2),
      .rsp_coef_3(rsp_coef_3),
      .rsp_coef_4(rsp_coef_4),
      .rsp_coef_5(rsp_coef_5),
      .rsp_status(rsp_status)
   );

endmodule

FILE: sv/qmj_checker.sv
// Port-level checker for the coefficient block and the bind that attaches it.
module qmj_checker #(
   parameter int WORD_BITS = qmj_pkg::WORD_BITS_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [WORD_BITS-1:0] req_start_position,
   input logic [WORD_BITS-1:0] req_start_velocity,
   input logic [WORD_BITS-1:0] req_start_accel,
   input logic [WORD_BITS-1:0] req_end_position,
   input logic [WORD_BITS-1:0] req_end_velocity,
   input logic [WORD_BITS-1:0] req_end_accel,
   input logic [WORD_BITS-2:0] req_duration,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [WORD_BITS-1:0] rsp_coef_0,
   input logic [WORD_BITS-1:0] rsp_coef_1,
   input logic [WORD_BITS-1:0] rsp_coef_2,
   input logic [WORD_BITS-1:0] rsp_coef_3,
   input logic [WORD_BITS-1:0] rsp_coef_4,
   input logic [WORD_BITS-1:0] rsp_coef_5,
   input logic [1:0]           rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_coef_3) && $stable(rsp_coef_4) && $stable(rsp_coef_5))
      else $error("stalled response transaction changed");

   a_zero_duration: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == qmj_pkg::STATUS_ZERO |->
         rsp_coef_0 == '0 && rsp_coef_1 == '0 && rsp_coef_2 == '0
         && rsp_coef_3 == '0 && rsp_coef_4 == '0 && rsp_coef_5 == '0)
      else $error("zero-duration response carries nonzero coefficients");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == qmj_pkg::STATUS_OK || rsp_status == qmj_pkg::STATUS_ZERO
         || rsp_status == qmj_pkg::STATUS_SAT)
      else $error("response status code out of range");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind quintic_min_jerk_coefficients qmj_checker #(.WORD_BITS(WORD_BITS)) u_qmj_checker (.*);
